### rtl/core/fscc_pkg.sv
// Shared constants, types and codes of the flash sector cache controller.
`timescale 1ns / 1ps

package fscc_pkg;

   localparam int SLOTS        = 4;
   localparam int SECTOR_BYTES = 4096;
   localparam int SECTOR_COUNT = 2048;

   localparam int KIND_W   = 2;
   localparam int SECTOR_W = 11;
   localparam int OFFSET_W = 12;
   localparam int COUNT_W  = 13;
   localparam int CMD_W    = 3;
   localparam int SLOT_W   = 2;
   localparam int SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SYNC  = 2'd2;

   typedef enum logic [CMD_W-1:0] {
      CMD_MERGE   = 3'd0,
      CMD_RDSLOT  = 3'd1,
      CMD_RDFLASH = 3'd2,
      CMD_FILL    = 3'd3,
      CMD_ERASE   = 3'd4,
      CMD_PROGRAM = 3'd5,
      CMD_NOSYNC  = 3'd6
   } cmd_type;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_SYNC  = 2'd2
   } op_type;

   typedef struct packed {
      op_type                op;
      logic [SECTOR_W-1:0]   sector;
      logic [OFFSET_W-1:0]   offset;
      logic [COUNT_W-1:0]    count;
   } q_entry_type;

endpackage

### rtl/core/fscc_front.sv
// Front end: accepts transactions, drops empty or out-of-range reads/writes, clamps spans.
`timescale 1ns / 1ps

module fscc_front
   import fscc_pkg::*;
(
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [SECTOR_W-1:0] req_sector,
   input  logic [OFFSET_W-1:0] req_byte_offset,
   input  logic [COUNT_W-1:0]  req_byte_count,
   input  logic                q_full,
   output logic                push_valid,
   output q_entry_type         push_data
);

   logic        accept;
   logic        span_ok;
   logic [31:0] room;
   logic [31:0] cnt_wide;

   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;

   assign span_ok = (req_byte_count != '0)
                 && (32'(req_byte_offset) < 32'(SECTOR_BYTES))
                 && (32'(req_sector) < 32'(SECTOR_COUNT));

   assign room     = 32'(SECTOR_BYTES) - 32'(req_byte_offset);
   assign cnt_wide = (32'(req_byte_count) > room) ? room : 32'(req_byte_count);

   always_comb begin
      push_data.sector = req_sector;
      push_data.offset = req_byte_offset;
      push_data.count  = cnt_wide[COUNT_W-1:0];
      push_data.op     = OP_WRITE;
      push_valid       = 1'b0;
      unique case (req_kind)
         KIND_WRITE: begin
            push_data.op = OP_WRITE;
            push_valid   = accept && span_ok;
         end
         KIND_READ: begin
            push_data.op = OP_READ;
            push_valid   = accept && span_ok;
         end
         KIND_SYNC: begin
            push_data.op = OP_SYNC;
            push_valid   = accept;
         end
         default: begin
            // unknown kind: take the transaction and drop it
            push_valid = 1'b0;
         end
      endcase
   end

endmodule

### rtl/core/fscc_queue.sv
// Two-entry queue between the request front end and the command sequencer.
`timescale 1ns / 1ps

module fscc_queue
   import fscc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push_valid,
   input  q_entry_type push_data,
   output logic        q_full,
   input  logic        pop,
   output logic        pop_valid,
   output q_entry_type pop_data
);

   q_entry_type entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        do_push;
   logic        do_pop;

   assign q_full    = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !q_full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/core/fscc_back.sv
// Command sequencer: slot tags, valid bits, round-robin victim pointer, command output register.
`timescale 1ns / 1ps

module fscc_back
   import fscc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  q_entry_type         q_data,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [CMD_W-1:0]    rsp_command,
   output logic [SLOT_W-1:0]   rsp_slot,
   output logic [SECTOR_W-1:0] rsp_target_sector,
   output logic [OFFSET_W-1:0] rsp_span_offset,
   output logic [COUNT_W-1:0]  rsp_span_count,
   output logic                rsp_last
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_WPROG  = 6'b000010,
      ST_WFILL  = 6'b000100,
      ST_WMERGE = 6'b001000,
      ST_SPROG  = 6'b010000,
      ST_SERASE = 6'b100000
   } state_type;

   state_type               st_ff, st_in;
   logic [SLOTS-1:0]        valid_ff, valid_in;
   logic [SECTOR_W-1:0]     tag_ff [SLOTS];
   logic [SLOT_IDX_W-1:0]   ptr_ff, ptr_in;

   logic [SLOT_IDX_W-1:0]   slot_ff, slot_in;
   logic [SECTOR_W-1:0]     sec_ff, sec_in;
   logic [OFFSET_W-1:0]     off_ff, off_in;
   logic [COUNT_W-1:0]      cnt_ff, cnt_in;
   logic [SECTOR_W-1:0]     old_ff, old_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CMD_W-1:0]        rsp_command_ff;
   logic [SLOT_W-1:0]       rsp_slot_ff;
   logic [SECTOR_W-1:0]     rsp_sector_ff;
   logic [OFFSET_W-1:0]     rsp_off_ff;
   logic [COUNT_W-1:0]      rsp_cnt_ff;
   logic                    rsp_last_ff;

   logic                    out_free;
   logic                    emit;
   cmd_type                 e_cmd;
   logic [SLOT_IDX_W-1:0]   e_idx;
   logic [SECTOR_W-1:0]     e_sector;
   logic [OFFSET_W-1:0]     e_off;
   logic [COUNT_W-1:0]      e_cnt;
   logic                    e_last;

   logic                    tag_we;
   logic [SLOT_IDX_W-1:0]   tag_wi;
   logic [SECTOR_W-1:0]     tag_wd;

   logic                    any_valid;
   logic [SLOT_IDX_W-1:0]   first_valid;
   logic                    rd_hit;
   logic [SLOT_IDX_W-1:0]   rd_idx_hit;
   logic                    w_found;
   logic                    w_empty;
   logic [SLOT_IDX_W-1:0]   w_idx;
   logic                    others_valid;
   logic [SLOT_IDX_W-1:0]   tag_rd_idx;
   logic [SECTOR_W-1:0]     tag_rd;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // slot searches, lowest index wins
   always_comb begin
      any_valid    = 1'b0;
      first_valid  = '0;
      rd_hit       = 1'b0;
      rd_idx_hit   = '0;
      w_found      = 1'b0;
      w_empty      = 1'b0;
      w_idx        = '0;
      others_valid = 1'b0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (valid_ff[i]) begin
            any_valid   = 1'b1;
            first_valid = SLOT_IDX_W'(i);
            if (SLOT_IDX_W'(i) != slot_ff) begin
               others_valid = 1'b1;
            end
         end
         if (valid_ff[i] && (tag_ff[i] == q_data.sector)) begin
            rd_hit     = 1'b1;
            rd_idx_hit = SLOT_IDX_W'(i);
         end
         if (!valid_ff[i] || (tag_ff[i] == q_data.sector)) begin
            w_found = 1'b1;
            w_empty = !valid_ff[i];
            w_idx   = SLOT_IDX_W'(i);
         end
      end
   end

   assign tag_rd_idx = ((st_ff == ST_SERASE) || (q_data.op == OP_SYNC)) ? first_valid : ptr_ff;
   assign tag_rd     = tag_ff[tag_rd_idx];

   always_comb begin
      st_in    = st_ff;
      valid_in = valid_ff;
      ptr_in   = ptr_ff;
      slot_in  = slot_ff;
      sec_in   = sec_ff;
      off_in   = off_ff;
      cnt_in   = cnt_ff;
      old_in   = old_ff;
      tag_we   = 1'b0;
      tag_wi   = slot_ff;
      tag_wd   = sec_ff;
      q_pop    = 1'b0;
      emit     = 1'b0;
      e_cmd    = CMD_MERGE;
      e_idx    = '0;
      e_sector = '0;
      e_off    = '0;
      e_cnt    = '0;
      e_last   = 1'b0;
      unique case (st_ff)
         ST_IDLE: begin
            if (q_valid && out_free) begin
               q_pop  = 1'b1;
               emit   = 1'b1;
               sec_in = q_data.sector;
               off_in = q_data.offset;
               cnt_in = q_data.count;
               unique case (q_data.op)
                  OP_READ: begin
                     e_cmd    = rd_hit ? CMD_RDSLOT : CMD_RDFLASH;
                     e_idx    = rd_hit ? rd_idx_hit : '0;
                     e_sector = q_data.sector;
                     e_off    = q_data.offset;
                     e_cnt    = q_data.count;
                     e_last   = 1'b1;
                  end
                  OP_WRITE: begin
                     if (w_found && !w_empty) begin
                        e_cmd    = CMD_MERGE;
                        e_idx    = w_idx;
                        e_sector = q_data.sector;
                        e_off    = q_data.offset;
                        e_cnt    = q_data.count;
                        e_last   = 1'b1;
                     end else if (w_found) begin
                        e_cmd           = CMD_FILL;
                        e_idx           = w_idx;
                        e_sector        = q_data.sector;
                        valid_in[w_idx] = 1'b1;
                        tag_we          = 1'b1;
                        tag_wi          = w_idx;
                        tag_wd          = q_data.sector;
                        slot_in         = w_idx;
                        st_in           = ST_WMERGE;
                     end else begin
                        // all slots taken by other sectors: write back the victim
                        e_cmd    = CMD_ERASE;
                        e_idx    = ptr_ff;
                        e_sector = tag_rd;
                        old_in   = tag_rd;
                        slot_in  = ptr_ff;
                        st_in    = ST_WPROG;
                     end
                  end
                  OP_SYNC: begin
                     if (!any_valid) begin
                        e_cmd  = CMD_NOSYNC;
                        e_last = 1'b1;
                        ptr_in = '0;
                     end else begin
                        e_cmd    = CMD_ERASE;
                        e_idx    = first_valid;
                        e_sector = tag_rd;
                        old_in   = tag_rd;
                        slot_in  = first_valid;
                        st_in    = ST_SPROG;
                     end
                  end
                  default: begin
                     emit = 1'b0;
                  end
               endcase
            end
         end
         ST_WPROG: begin
            if (out_free) begin
               emit     = 1'b1;
               e_cmd    = CMD_PROGRAM;
               e_idx    = slot_ff;
               e_sector = old_ff;
               st_in    = ST_WFILL;
            end
         end
         ST_WFILL: begin
            if (out_free) begin
               emit     = 1'b1;
               e_cmd    = CMD_FILL;
               e_idx    = slot_ff;
               e_sector = sec_ff;
               tag_we   = 1'b1;
               ptr_in   = (slot_ff == SLOT_IDX_W'(SLOTS - 1)) ? '0
                                                              : slot_ff + SLOT_IDX_W'(1);
               st_in    = ST_WMERGE;
            end
         end
         ST_WMERGE: begin
            if (out_free) begin
               emit     = 1'b1;
               e_cmd    = CMD_MERGE;
               e_idx    = slot_ff;
               e_sector = sec_ff;
               e_off    = off_ff;
               e_cnt    = cnt_ff;
               e_last   = 1'b1;
               st_in    = ST_IDLE;
            end
         end
         ST_SPROG: begin
            if (out_free) begin
               emit              = 1'b1;
               e_cmd             = CMD_PROGRAM;
               e_idx             = slot_ff;
               e_sector          = old_ff;
               valid_in[slot_ff] = 1'b0;
               if (!others_valid) begin
                  e_last = 1'b1;
                  ptr_in = '0;
                  st_in  = ST_IDLE;
               end else begin
                  st_in = ST_SERASE;
               end
            end
         end
         ST_SERASE: begin
            if (out_free) begin
               emit     = 1'b1;
               e_cmd    = CMD_ERASE;
               e_idx    = first_valid;
               e_sector = tag_rd;
               old_in   = tag_rd;
               slot_in  = first_valid;
               st_in    = ST_SPROG;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         valid_ff     <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         valid_ff     <= valid_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      sec_ff  <= sec_in;
      off_ff  <= off_in;
      cnt_ff  <= cnt_in;
      old_ff  <= old_in;
      if (tag_we) begin
         tag_ff[tag_wi] <= tag_wd;
      end
      if (emit) begin
         rsp_command_ff <= e_cmd;
         rsp_slot_ff    <= SLOT_W'(e_idx);
         rsp_sector_ff  <= e_sector;
         rsp_off_ff     <= e_off;
         rsp_cnt_ff     <= e_cnt;
         rsp_last_ff    <= e_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_command       = rsp_command_ff;
   assign rsp_slot          = rsp_slot_ff;
   assign rsp_target_sector = rsp_sector_ff;
   assign rsp_span_offset   = rsp_off_ff;
   assign rsp_span_count    = rsp_cnt_ff;
   assign rsp_last          = rsp_last_ff;

   a_nosync_empty : assert property (@(posedge clock) disable iff (reset)
      (emit && (e_cmd == CMD_NOSYNC)) |-> (valid_ff == '0))
      else $error("nothing-to-sync issued with a valid slot");

   a_fill_sets_valid : assert property (@(posedge clock) disable iff (reset)
      (emit && (e_cmd == CMD_FILL)) |=> valid_ff[$past(e_idx)])
      else $error("filled slot not marked valid");

   a_rdslot_hit : assert property (@(posedge clock) disable iff (reset)
      (emit && (e_cmd == CMD_RDSLOT)) |-> (valid_ff[e_idx] && (tag_ff[e_idx] == e_sector)))
      else $error("read slot issued without a matching tag");

   a_sync_clears : assert property (@(posedge clock) disable iff (reset)
      (emit && e_last && (st_ff == ST_SPROG)) |=> ((valid_ff == '0) && (ptr_ff == '0)))
      else $error("sync finished with slots still valid");

endmodule

### rtl/core/flash_sector_cache_controller_top.sv
// Top level of the flash sector cache controller: front end, queue and command sequencer.
`timescale 1ns / 1ps

// Usage
//   req_* carries one transaction per request: kind (write, read, sync), sector,
//   byte offset and byte count of one span inside one sector. A request is taken
//   when req_valid is high and req_stall is low.
//   rsp_* carries the datapath commands the request causes, one or more per
//   transaction, rsp_last marking the final one. Empty or out-of-range reads and
//   writes and requests of an unknown kind are taken and produce no commands.
// Command flow
//   Requests pass the queue, then the sequencer's output register. The sequencer
//   issues one command per cycle unless stalled, one request at a time: one for
//   a read or write hit; fill, merge for a write to an empty slot; erase,
//   program, fill, merge for an eviction; erase, program per valid slot for a
//   sync (nothing-to-sync if none). The queue takes requests meanwhile.
// Reset
//   Synchronous reset empties all slots, sets the victim pointer to zero and
//   drops queued requests and a pending command. Tags need no reset.
// Stall
//   While rsp_stall is high a pending command holds; the sequencer waits, and
//   req_stall rises once the queue holds two requests.

module flash_sector_cache_controller_top
   import fscc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [SECTOR_W-1:0] req_sector,
   input  logic [OFFSET_W-1:0] req_byte_offset,
   input  logic [COUNT_W-1:0]  req_byte_count,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [CMD_W-1:0]    rsp_command,
   output logic [SLOT_W-1:0]   rsp_slot,
   output logic [SECTOR_W-1:0] rsp_target_sector,
   output logic [OFFSET_W-1:0] rsp_span_offset,
   output logic [COUNT_W-1:0]  rsp_span_count,
   output logic                rsp_last
);

   logic        q_full;
   logic        push_valid;
   q_entry_type push_data;
   logic        q_pop;
   logic        q_valid;
   q_entry_type q_data;

   fscc_front u_front (
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_sector      (req_sector),
      .req_byte_offset (req_byte_offset),
      .req_byte_count  (req_byte_count),
      .q_full          (q_full),
      .push_valid      (push_valid),
      .push_data       (push_data)
   );

   fscc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .q_full     (q_full),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_data   (q_data)
   );

   fscc_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_data            (q_data),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_command       (rsp_command),
      .rsp_slot          (rsp_slot),
      .rsp_target_sector (rsp_target_sector),
      .rsp_span_offset   (rsp_span_offset),
      .rsp_span_count    (rsp_span_count),
      .rsp_last          (rsp_last)
   );

endmodule
